>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the view grid block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

>>> rtl/vgb_pkg.sv
// Package for the view grid basis block: widths, CORDIC constants, helpers.
// No dependencies.
package vgb_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS = 14;
  localparam int WORK_BITS = 30;
  localparam int STEPS = 30;
  localparam int OUT_BITS = FRAC_BITS + 2;
  localparam int W = 33;
  localparam logic signed [W-1:0] INV_GAIN = 33'sd652032874;
  localparam logic signed [W-1:0] ONE = 33'sd1073741824;

  function automatic logic signed [W-1:0] atan_tab(input int i);
    logic signed [W-1:0] t [STEPS] = '{
      33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
      33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
      33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772,
      33'sd166886, 33'sd83443, 33'sd41722, 33'sd20861, 33'sd10430,
      33'sd5215, 33'sd2608, 33'sd1304, 33'sd652, 33'sd326, 33'sd163,
      33'sd81, 33'sd41, 33'sd20, 33'sd10, 33'sd5, 33'sd3, 33'sd1};
    return t[i];
  endfunction

  function automatic logic signed [W-1:0] clamp1(input logic signed [W-1:0] v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] emit(input logic signed [W-1:0] q);
    logic signed [W:0] r;
    logic signed [W:0] o;
    r = (signed'({q[W-1], q}) + (W+1)'(1 <<< (WORK_BITS - FRAC_BITS - 1))) >>>
        (WORK_BITS - FRAC_BITS);
    o = (W+1)'(1 <<< FRAC_BITS);
    if (r > o) r = o;
    if (r < -o) r = -o;
    return r[OUT_BITS-1:0];
  endfunction

  typedef struct packed {
    logic signed [W-1:0] s;
    logic signed [W-1:0] c;
  } sc_t;
endpackage

>>> rtl/vgb_cordic.sv
// Pipelined CORDIC: one rotation step per register stage, sine and cosine out.
// Depends on vgb_pkg.
module vgb_cordic import vgb_pkg::*; (
  input  logic                  clk,
  input  logic [ANGLE_BITS-1:0] angle,
  output sc_t                   result
);
  logic signed [W-1:0] x [STEPS+1];
  logic signed [W-1:0] y [STEPS+1];
  logic signed [W-1:0] z [STEPS+1];
  logic                flip [STEPS+1];
  logic [31:0] a0;
  logic [31:0] a1;
  logic        f0;

  always_comb begin
    a0 = {angle, {(32-ANGLE_BITS){1'b0}}};
    f0 = (a0 + 32'h4000_0000) >= 32'h8000_0000;
    a1 = f0 ? a0 - 32'h8000_0000 : a0;
  end

  always_ff @(posedge clk) begin
    x[0] <= INV_GAIN;
    y[0] <= '0;
    z[0] <= W'(signed'(a1));
    flip[0] <= f0;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      flip[i+1] <= flip[i];
      if (!z[i][W-1]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - atan_tab(i);
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + atan_tab(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    result.c <= flip[STEPS] ? -clamp1(x[STEPS]) : clamp1(x[STEPS]);
    result.s <= flip[STEPS] ? -clamp1(y[STEPS]) : clamp1(y[STEPS]);
  end
endmodule

>>> rtl/view_grid_basis_vectors_core.sv
// Top level of the view grid basis block: three CORDICs, products, roll.
// Depends on vgb_pkg and vgb_cordic.
// done follows start through the CORDICs and stages A to D; one request per cycle.
// busy is always low; the block keeps no state besides its pipeline.
// rst clears the valid bits synchronously; payload registers are not reset.
module view_grid_basis_vectors_core import vgb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [15:0]         azimuth,
  input  logic signed [15:0]         elevation,
  input  logic signed [15:0]         roll_angle,
  output logic                       done,
  output logic signed [OUT_BITS-1:0] h_x,
  output logic signed [OUT_BITS-1:0] h_y,
  output logic signed [OUT_BITS-1:0] h_z,
  output logic signed [OUT_BITS-1:0] v_x,
  output logic signed [OUT_BITS-1:0] v_y,
  output logic signed [OUT_BITS-1:0] v_z
);
  localparam int CL = STEPS + 2;
  localparam int LAT = CL + 4;
  localparam int PW = 2 * W;
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (WORK_BITS - 1);

  sc_t az, el, rl;
  logic [LAT-1:0] vld;
  logic [CL-1:0]  rz;

  assign busy = 1'b0;

  vgb_cordic u_az (.clk(clk), .angle(azimuth[ANGLE_BITS-1:0]), .result(az));
  vgb_cordic u_el (.clk(clk), .angle(elevation[ANGLE_BITS-1:0]), .result(el));
  vgb_cordic u_rl (.clk(clk), .angle(roll_angle[ANGLE_BITS-1:0]), .result(rl));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
    rz <= {rz[CL-2:0], roll_angle[ANGLE_BITS-1:0] == '0};
  end

  // stage A: elevation products
  logic signed [PW-1:0] p_x, p_y;
  sc_t a_az, a_rl;
  logic signed [W-1:0] a_elc;
  logic a_rz;
  always_ff @(posedge clk) begin
    p_x <= PW'(el.s) * PW'(az.c);
    p_y <= PW'(el.s) * PW'(az.s);
    a_az <= az; a_elc <= el.c; a_rl <= rl; a_rz <= rz[CL-1];
  end

  // stage B: unrotated vectors
  logic signed [W-1:0] h0 [3];
  logic signed [W-1:0] v0 [3];
  sc_t b_rl;
  logic b_rz;
  always_ff @(posedge clk) begin
    h0[0] <= -a_az.s;
    h0[1] <= a_az.c;
    h0[2] <= '0;
    v0[0] <= -W'((p_x + RND) >>> WORK_BITS);
    v0[1] <= -W'((p_y + RND) >>> WORK_BITS);
    v0[2] <= a_elc;
    b_rl <= a_rl; b_rz <= a_rz;
  end

  // stage C: roll products
  logic signed [PW-1:0] ch [3], sv [3], cv [3], sh [3];
  logic signed [W-1:0] h1 [3];
  logic signed [W-1:0] v1 [3];
  logic signed [OUT_BITS-1:0] ho [3];
  logic signed [OUT_BITS-1:0] vo [3];
  logic c_rz;
  for (genvar k = 0; k < 3; k++) begin : g_roll
    always_ff @(posedge clk) begin
      ch[k] <= PW'(b_rl.c) * PW'(h0[k]);
      sv[k] <= PW'(b_rl.s) * PW'(v0[k]);
      cv[k] <= PW'(b_rl.c) * PW'(v0[k]);
      sh[k] <= PW'(b_rl.s) * PW'(h0[k]);
      h1[k] <= h0[k];
      v1[k] <= v0[k];
    end
    // stage D: sums, select, round to output
    always_ff @(posedge clk) begin
      if (c_rz) begin
        ho[k] <= emit(h1[k]);
        vo[k] <= emit(v1[k]);
      end else begin
        ho[k] <= emit(W'((ch[k] - sv[k] + RND) >>> WORK_BITS));
        vo[k] <= emit(W'((cv[k] + sh[k] + RND) >>> WORK_BITS));
      end
    end
  end
  always_ff @(posedge clk) c_rz <= b_rz;

  assign h_x = ho[0];
  assign h_y = ho[1];
  assign h_z = ho[2];
  assign v_x = vo[0];
  assign v_y = vo[1];
  assign v_z = vo[2];

  assign done = vld[LAT-1];
endmodule

>>> rtl/vgb_checker.sv
// Port-level checker for the view grid basis block, bound to the top level.
// Depends on vgb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module vgb_checker import vgb_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic signed [OUT_BITS-1:0] h_x,
  input logic signed [OUT_BITS-1:0] h_y,
  input logic signed [OUT_BITS-1:0] v_z
);
  localparam logic signed [OUT_BITS-1:0] LIM = OUT_BITS'(1 <<< FRAC_BITS);
  `CHK_IMPLY(a_never_busy, clk, rst, 1'b1, !busy)
  `CHK_IMPLY(a_hx_range, clk, rst, done, h_x <= LIM && h_x >= -LIM)
  `CHK_IMPLY(a_hy_range, clk, rst, done, h_y <= LIM && h_y >= -LIM)
  `CHK_IMPLY(a_vz_range, clk, rst, done, v_z <= LIM && v_z >= -LIM)
  `CHK_NEXT(a_idle_reset, clk, 1'b0, rst, !done)
endmodule

bind view_grid_basis_vectors_core vgb_checker u_vgb_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .h_x(h_x), .h_y(h_y), .v_z(v_z)
);
